@@ sv/lbc_pkg.sv @@
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared constants and types for the per-node LRU block cache.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int NODES_DEF   = 8;
  localparam int WAYS_DEF    = 16;
  localparam int ID_BITS_DEF = 32;

  localparam int MODE_W     = 2;
  localparam int NODE_IN_W  = 3;
  localparam int BLOCK_IN_W = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_FILL   = 2'd1,
    MODE_FLUSH  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_WB   = 3'b100
  } state_t;

endpackage

@@ sv/lbc_tag_mem.sv @@
// ----------------------------------------------------------------------------
// lbc_tag_mem
// Tag row memory: one row of WAYS identifiers per node, registered read.
// ----------------------------------------------------------------------------
module lbc_tag_mem #(
  parameter int NODES  = 8,
  parameter int ROW_W  = 512,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [ROW_W-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ROW_W-1:0]  wr_data
);

  logic [ROW_W-1:0] mem [NODES];
  logic [ROW_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/lbc_lookup.sv @@
// ----------------------------------------------------------------------------
// lbc_lookup
// Compares a tag against all valid ways of a row and registers the hit and
// the position of the first match.
// ----------------------------------------------------------------------------
module lbc_lookup #(
  parameter int WAYS    = 16,
  parameter int ID_BITS = 32,
  parameter int CNT_W   = 5,
  parameter int WAY_W   = 4
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [WAYS-1:0][ID_BITS-1:0]   row,
  input  logic [ID_BITS-1:0]             tag,
  input  logic [CNT_W-1:0]               cnt,
  output logic                           hit,
  output logic [WAY_W-1:0]               pos
);

  logic [WAYS-1:0]  match;
  logic [WAY_W-1:0] pos_nxt;
  logic             hit_r;
  logic [WAY_W-1:0] pos_r;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      match[i] = (CNT_W'(i) < cnt) && (row[i] == tag);
    end
  end

  // The lowest matching way is the most recent copy.
  always_comb begin
    pos_nxt = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos_nxt = WAY_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= |match;
      pos_r <= pos_nxt;
    end
  end

  assign hit = hit_r;
  assign pos = pos_r;

endmodule

@@ sv/lru_block_cache_per_node_unit.sv @@
// ----------------------------------------------------------------------------
// lru_block_cache_per_node_unit
// Per-node fully associative LRU cache of block identifiers.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_mode, in_node and in_block_id and raise start; the item is taken
//   at a clock edge where start is high and busy is low. Mode lookup reports
//   presence, fill promotes or inserts the block as most recent (evicting the
//   least recent entry of a full list), flush empties the node's list.
//   Each item yields exactly one result, shown for one cycle with out_valid
//   high: out_hit, out_evicted and out_evicted_block.
//   The tag row is read at the accepting edge; busy is high in ST_CMP
//   and ST_WB, so no item is taken before its predecessor is through, and
//   out_valid is registered in ST_WB. The three steps are the tag row
//   read, the compare of all ways, and the write back of the reordered row.
//   A new item may be accepted at the edge that ends its predecessor's
//   result cycle.
//   The receiver cannot stall; a result must be taken when shown.
//   Reset (rst_n low, synchronous) empties every node's list. The tag memory
//   itself is not cleared; only valid entries of a row are ever compared.
// ----------------------------------------------------------------------------
module lru_block_cache_per_node_unit #(
  parameter int NODES   = lbc_pkg::NODES_DEF,
  parameter int WAYS    = lbc_pkg::WAYS_DEF,
  parameter int ID_BITS = lbc_pkg::ID_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [lbc_pkg::MODE_W-1:0]      in_mode,
  input  logic [lbc_pkg::NODE_IN_W-1:0]   in_node,
  input  logic [lbc_pkg::BLOCK_IN_W-1:0]  in_block_id,
  output logic                            out_valid,
  output logic                            out_hit,
  output logic                            out_evicted,
  output logic [lbc_pkg::BLOCK_IN_W-1:0]  out_evicted_block
);

  import lbc_pkg::*;

  localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CNT_W  = $clog2(WAYS + 1);
  localparam int WAY_W  = $clog2(WAYS);
  localparam int ROW_W  = WAYS * ID_BITS;

  state_t                   state_r, state_nxt;
  mode_t                    mode_r;
  logic [NODE_W-1:0]        node_r;
  logic                     in_range_r;
  logic [ID_BITS-1:0]       tag_r;
  logic [CNT_W-1:0]         cnt_r [NODES];
  logic [CNT_W-1:0]         cur_cnt;
  logic                     accept;

  logic [ROW_W-1:0]               rd_data;
  logic [WAYS-1:0][ID_BITS-1:0]   row;
  logic [WAYS-1:0][ID_BITS-1:0]   new_row;
  logic                           hit;
  logic [WAY_W-1:0]               pos;
  logic                           full;
  logic [CNT_W-1:0]               shift_len;
  logic                           do_fill;
  logic                           do_evict;

  logic                           out_valid_r;
  logic                           out_hit_r;
  logic                           out_evicted_r;
  logic [BLOCK_IN_W-1:0]          out_evicted_block_r;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign row    = rd_data;

  always_comb begin
    cur_cnt = '0;
    if (in_range_r) begin
      cur_cnt = cnt_r[node_r];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_WB;
      ST_WB:   state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= mode_t'(in_mode);
      node_r     <= NODE_W'(in_node);
      in_range_r <= (32'(in_node) < NODES);
      tag_r      <= ID_BITS'(in_block_id);
    end
  end

  lbc_tag_mem #(
    .NODES  (NODES),
    .ROW_W  (ROW_W),
    .ADDR_W (NODE_W)
  ) u_tag_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (NODE_W'(in_node)),
    .rd_data (rd_data),
    .wr_en   (state_r == ST_WB && do_fill),
    .wr_addr (node_r),
    .wr_data (new_row)
  );

  lbc_lookup #(
    .WAYS    (WAYS),
    .ID_BITS (ID_BITS),
    .CNT_W   (CNT_W),
    .WAY_W   (WAY_W)
  ) u_lookup (
    .clk (clk),
    .en  (state_r == ST_CMP),
    .row (row),
    .tag (tag_r),
    .cnt (cur_cnt),
    .hit (hit),
    .pos (pos)
  );

  assign full     = (cur_cnt >= CNT_W'(WAYS));
  assign do_fill  = in_range_r && (mode_r == MODE_FILL);
  assign do_evict = do_fill && !hit && full;

  // A hit moves the block up from its own position; a miss shifts the
  // whole valid part of the list, dropping the tail when it is full.
  always_comb begin
    if (hit) begin
      shift_len = CNT_W'(pos);
    end else if (full) begin
      shift_len = CNT_W'(WAYS - 1);
    end else begin
      shift_len = cur_cnt;
    end
  end

  always_comb begin
    new_row[0] = tag_r;
    for (int i = 1; i < WAYS; i++) begin
      if (CNT_W'(i) <= shift_len) begin
        new_row[i] = row[i-1];
      end else begin
        new_row[i] = row[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < NODES; n++) begin
        cnt_r[n] <= '0;
      end
    end else if (state_r == ST_WB && in_range_r) begin
      if (mode_r == MODE_FLUSH) begin
        cnt_r[node_r] <= '0;
      end else if (do_fill && !hit && !full) begin
        cnt_r[node_r] <= cur_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_WB);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WB) begin
      out_hit_r     <= in_range_r && hit;
      out_evicted_r <= do_evict;
      if (do_evict) begin
        out_evicted_block_r <= BLOCK_IN_W'(row[WAYS-1]);
      end else begin
        out_evicted_block_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_evicted       = out_evicted_r;
  assign out_evicted_block = out_evicted_block_r;

endmodule
